>>> hdl/rvid_pkg.sv
package rvid_pkg;

	localparam int NUM_REGISTERS_DEF = 32;
	localparam int XLEN = 32;
	localparam int REG_IDX_W = 5;

	// major opcodes
	localparam logic [6:0] OPC_OP     = 7'd51;
	localparam logic [6:0] OPC_OP_IMM = 7'd19;
	localparam logic [6:0] OPC_LOAD   = 7'd3;
	localparam logic [6:0] OPC_STORE  = 7'd35;
	localparam logic [6:0] OPC_LUI    = 7'd55;
	localparam logic [6:0] OPC_AUIPC  = 7'd23;
	localparam logic [6:0] OPC_JAL    = 7'd111;
	localparam logic [6:0] OPC_JALR   = 7'd103;
	localparam logic [6:0] OPC_BRANCH = 7'd99;

	// func3 codes used in the checks
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_WORD = 3'd2;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	typedef enum logic [3:0] {
		ALU_NONE = 4'd0,
		ALU_ADD  = 4'd1,
		ALU_SLL  = 4'd2,
		ALU_SLT  = 4'd3,
		ALU_SLTU = 4'd4,
		ALU_XOR  = 4'd5,
		ALU_SRL  = 4'd6,
		ALU_OR   = 4'd7,
		ALU_AND  = 4'd8,
		ALU_MUL  = 4'd9,
		ALU_SUB  = 4'd10,
		ALU_SRA  = 4'd11,
		ALU_EQ   = 4'd12,
		ALU_NE   = 4'd13,
		ALU_GE   = 4'd14,
		ALU_GEU  = 4'd15
	} alu_op_t;

	typedef enum logic [2:0] {
		CTL_BRANCH = 3'd0,
		CTL_WB     = 3'd1,
		CTL_LOAD   = 3'd2,
		CTL_STORE  = 3'd3,
		CTL_JUMP   = 3'd4
	} ctl_t;

	typedef struct packed {
		alu_op_t           alu_op;
		logic [XLEN-1:0]   dest;
		logic [XLEN-1:0]   operand_a;
		logic [XLEN-1:0]   operand_b;
		ctl_t              control;
		logic              invalid;
	} dec_t;

endpackage

>>> hdl/rvid_regfile.sv
module rvid_regfile
	import rvid_pkg::*;
#(
	parameter int NUM_REGISTERS = NUM_REGISTERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_idx,
	input  logic [XLEN-1:0]      wr_data,
	input  logic                 rd_en,
	input  logic [REG_IDX_W-1:0] rd_idx_a,
	input  logic [REG_IDX_W-1:0] rd_idx_b,
	output logic [XLEN-1:0]      rd_data_a,
	output logic [XLEN-1:0]      rd_data_b
);

	localparam int IDX_W = $clog2(NUM_REGISTERS);

	logic [XLEN-1:0]          mem [NUM_REGISTERS];
	logic [NUM_REGISTERS-1:0] written_q;
	logic [XLEN-1:0]          rd_a_s1;
	logic [XLEN-1:0]          rd_b_s1;
	logic                     ok_a_s1;
	logic                     ok_b_s1;
	logic                     wr_in_range;
	logic                     a_in_range;
	logic                     b_in_range;

	assign wr_in_range = {1'b0, wr_idx} < (REG_IDX_W+1)'(NUM_REGISTERS);
	assign a_in_range  = {1'b0, rd_idx_a} < (REG_IDX_W+1)'(NUM_REGISTERS);
	assign b_in_range  = {1'b0, rd_idx_b} < (REG_IDX_W+1)'(NUM_REGISTERS);

	always_ff @(posedge clk) begin
		if (wr_en && wr_in_range) begin
			mem[wr_idx[IDX_W-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_a_s1 <= mem[rd_idx_a[IDX_W-1:0]];
			rd_b_s1 <= mem[rd_idx_b[IDX_W-1:0]];
		end
	end

	// an entry never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			ok_a_s1   <= 1'b0;
			ok_b_s1   <= 1'b0;
		end else begin
			if (wr_en && wr_in_range) begin
				written_q[wr_idx[IDX_W-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				ok_a_s1 <= a_in_range && written_q[rd_idx_a[IDX_W-1:0]];
				ok_b_s1 <= b_in_range && written_q[rd_idx_b[IDX_W-1:0]];
			end
		end
	end

	assign rd_data_a = ok_a_s1 ? rd_a_s1 : '0;
	assign rd_data_b = ok_b_s1 ? rd_b_s1 : '0;

endmodule

>>> hdl/rvid_decode.sv
module rvid_decode
	import rvid_pkg::*;
(
	input  logic [XLEN-1:0] instr,
	input  logic [XLEN-1:0] pc,
	input  logic [XLEN-1:0] rs1_val,
	input  logic [XLEN-1:0] rs2_val,
	output dec_t            dec
);

	logic [6:0]      opc;
	logic [2:0]      f3;
	logic [6:0]      f7;
	logic [XLEN-1:0] rd_word;
	logic [XLEN-1:0] imm_i;
	logic [XLEN-1:0] imm_s;
	logic [XLEN-1:0] imm_b;
	logic [XLEN-1:0] imm_j;
	logic [XLEN-1:0] imm_u;
	alu_op_t         base_op;

	assign opc     = instr[6:0];
	assign f3      = instr[14:12];
	assign f7      = instr[31:25];
	assign rd_word = {{(XLEN-REG_IDX_W){1'b0}}, instr[11:7]};
	assign imm_i   = {{20{instr[31]}}, instr[31:20]};
	assign imm_s   = {{20{instr[31]}}, instr[31:25], instr[11:7]};
	assign imm_b   = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
	assign imm_j   = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
	assign imm_u   = {instr[31:12], 12'd0};
	// func3 maps straight onto the eight base operations
	assign base_op = alu_op_t'({1'b0, f3} + 4'd1);

	always_comb begin
		dec = '{alu_op: ALU_NONE, dest: '0, operand_a: '0, operand_b: '0,
			control: CTL_BRANCH, invalid: 1'b0};
		case (opc)
			OPC_OP: begin
				dec.dest      = rd_word;
				dec.operand_a = rs1_val;
				dec.operand_b = rs2_val;
				dec.control   = CTL_WB;
				if (f7 == 7'd0) begin
					dec.alu_op = base_op;
				end else if (f7[0]) begin
					if (f3 == F3_ADD) dec.alu_op = ALU_MUL;
					else dec.invalid = 1'b1;
				end else if (f7[5]) begin
					if (f3 == F3_ADD) dec.alu_op = ALU_SUB;
					else if (f3 == F3_SR) dec.alu_op = ALU_SRA;
					else dec.invalid = 1'b1;
				end else begin
					dec.invalid = 1'b1;
				end
			end
			OPC_OP_IMM: begin
				dec.dest      = rd_word;
				dec.operand_a = rs1_val;
				dec.operand_b = imm_i;
				dec.control   = CTL_WB;
				if (f3 == F3_SR) begin
					if (instr[30]) dec.alu_op = ALU_SRA;
					else if (f7 == 7'd0) dec.alu_op = ALU_SRL;
					else dec.invalid = 1'b1;
				end else begin
					dec.alu_op = base_op;
				end
			end
			OPC_LOAD: begin
				dec.dest      = rd_word;
				dec.operand_a = imm_i;
				dec.operand_b = rs1_val;
				dec.control   = CTL_LOAD;
				dec.invalid   = (f3 != F3_WORD);
			end
			OPC_STORE: begin
				dec.dest      = rs2_val;
				dec.operand_a = rs1_val;
				dec.operand_b = imm_s;
				dec.control   = CTL_STORE;
				dec.invalid   = (f3 != F3_WORD);
			end
			OPC_LUI: begin
				dec.dest      = rd_word;
				dec.operand_a = imm_u;
				dec.control   = CTL_WB;
			end
			OPC_AUIPC: begin
				dec.dest      = rd_word;
				dec.operand_a = imm_u;
				dec.operand_b = pc;
				dec.control   = CTL_WB;
			end
			OPC_JAL: begin
				dec.dest      = rd_word;
				dec.operand_a = pc;
				dec.operand_b = imm_j;
				dec.control   = CTL_JUMP;
			end
			OPC_JALR: begin
				dec.dest      = rd_word;
				dec.operand_a = rs1_val;
				dec.operand_b = imm_i;
				dec.control   = CTL_JUMP;
				dec.invalid   = (f3 != F3_ADD);
			end
			OPC_BRANCH: begin
				dec.dest      = imm_b;
				dec.operand_a = rs1_val;
				dec.operand_b = rs2_val;
				dec.control   = CTL_BRANCH;
				case (f3)
					F3_BEQ:  dec.alu_op = ALU_EQ;
					F3_BNE:  dec.alu_op = ALU_NE;
					F3_BLT:  dec.alu_op = ALU_SLT;
					F3_BGE:  dec.alu_op = ALU_GE;
					F3_BLTU: dec.alu_op = ALU_SLTU;
					F3_BGEU: dec.alu_op = ALU_GEU;
					default: dec.invalid = 1'b1;
				endcase
			end
			default: begin
				dec.invalid = 1'b1;
			end
		endcase
	end

endmodule

>>> hdl/rv32_instruction_decode.sv
// RV32 instruction decoder with its own register file.
// Input channel s_*: one beat is one item. s_tuser selects the kind of item:
// 0 decodes the instruction in s_tdata against the register file, 1 writes
// write_value into register write_index and gives no result beat.
// Output channel m_*: one beat per decode, carrying the ALU operation, the
// destination word and both operands in m_tdata, control class and invalid
// flag in m_tuser.
// A decode accepted on s_* has its register file read registered in the read
// stage; its decoded result is then registered in the result register and
// offered on m_*. Throughput is one item per cycle unless m_* stalls, set by
// the single read stage and the result register; a write item updates the
// file at its acceptance edge, so a decode in the very next beat sees it.
// Reset clears every register of the file to zero (a per-entry written flag)
// and empties both stages; no clearing pass is needed.
// When the receiver stalls, the result register holds, the read stage holds
// behind it, and s_tready falls only once both stages are full.
module rv32_instruction_decode
	import rvid_pkg::*;
#(
	parameter int NUM_REGISTERS = NUM_REGISTERS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// instruction[31:0], pc[63:32], write_index[68:64], write_value[100:69], zero fill
	input  logic [103:0] s_tdata,
	// operation[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// alu_op[3:0], dest[35:4], operand_a[67:36], operand_b[99:68], zero fill
	output logic [103:0] m_tdata,
	// control[2:0], invalid[3]
	output logic [3:0]   m_tuser
);

	logic            s_beat;
	logic            dec_beat;
	logic            wr_beat;
	logic            s1_valid_q;
	logic [XLEN-1:0] instr_s1;
	logic [XLEN-1:0] pc_s1;
	logic [XLEN-1:0] rs1_val;
	logic [XLEN-1:0] rs2_val;
	logic            out_valid_q;
	dec_t            out_q;
	dec_t            dec;
	logic            out_free;
	logic            s1_move;

	// the result register frees when empty or when its beat is taken
	assign out_free = !out_valid_q || m_tready;
	assign s1_move  = s1_valid_q && out_free;
	assign s_tready = !s1_valid_q || out_free;
	assign s_beat   = s_tvalid && s_tready;
	assign dec_beat = s_beat && !s_tuser;
	assign wr_beat  = s_beat && s_tuser;

	rvid_regfile #(
		.NUM_REGISTERS(NUM_REGISTERS)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_beat),
		.wr_idx   (s_tdata[68:64]),
		.wr_data  (s_tdata[100:69]),
		.rd_en    (dec_beat),
		.rd_idx_a (s_tdata[19:15]),
		.rd_idx_b (s_tdata[24:20]),
		.rd_data_a(rs1_val),
		.rd_data_b(rs2_val)
	);

	// read stage: hold the instruction next to its register values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= dec_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_beat) begin
			instr_s1 <= s_tdata[31:0];
			pc_s1    <= s_tdata[63:32];
		end
	end

	rvid_decode u_decode (
		.instr  (instr_s1),
		.pc     (pc_s1),
		.rs1_val(rs1_val),
		.rs2_val(rs2_val),
		.dec    (dec)
	);

	// result register: advance on a free slot, drop the valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q <= dec;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q.operand_b, out_q.operand_a, out_q.dest, out_q.alu_op};
	assign m_tuser  = {out_q.invalid, out_q.control};

`ifndef SYNTHESIS
	// a write item never reaches the read stage
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		wr_beat |=> !s1_valid_q)
		else $error("write beat left an entry in the read stage");

	// a decode beat always lands in the read stage
	a_decode_enters: assert property (@(posedge clk) disable iff (!arst_n)
		dec_beat |=> s1_valid_q)
		else $error("decode beat lost at the read stage");

	// a stalled read stage keeps its instruction
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_free |=> s1_valid_q && $stable(instr_s1))
		else $error("read stage changed while stalled");

	// an operation code is given only for a recognised instruction
	a_op_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[3:0] != ALU_NONE) |-> !m_tuser[3])
		else $error("operation code on an invalid instruction");

	// a valid branch always carries a compare
	a_branch_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] == CTL_BRANCH) && !m_tuser[3] |->
		(m_tdata[3:0] == ALU_EQ) || (m_tdata[3:0] == ALU_NE) ||
		(m_tdata[3:0] == ALU_SLT) || (m_tdata[3:0] == ALU_GE) ||
		(m_tdata[3:0] == ALU_SLTU) || (m_tdata[3:0] == ALU_GEU))
		else $error("branch without a compare operation");
`endif

endmodule
